// ===== rtl/sc1a_pkg.sv =====
// Package for the set-1 scan code to ASCII unit.
// Holds the code constants, the key memory sizing and the two-column character ROM.
// Depends on nothing; imported by scancode_set1_to_ascii_unit.
package sc1a_pkg;

	localparam int KEY_COUNT = 96;
	localparam int KEY_IDX_W = $clog2(KEY_COUNT);
	localparam int ROM_SIZE  = 96;
	localparam int CODE_W    = 7;

	localparam logic [7:0]        PREFIX_BYTE   = 8'hE0;
	localparam logic [CODE_W-1:0] CODE_NUMLOCK  = 7'h45;
	localparam logic [CODE_W-1:0] CODE_CAPSLOCK = 7'h3A;
	localparam logic [CODE_W-1:0] CODE_SCRLOCK  = 7'h46;
	localparam logic [CODE_W-1:0] CODE_LSHIFT   = 7'h2A;
	localparam logic [CODE_W-1:0] CODE_SLASH    = 7'h35;

	// Lock flag bit positions, same layout as the LED byte.
	localparam int LOCK_CAPS   = 2;
	localparam int LOCK_NUM    = 1;
	localparam int LOCK_SCROLL = 0;

	typedef logic [6:0] ascii_t;
	typedef logic [1:0] held_t;

	localparam ascii_t ROM_PLAIN [ROM_SIZE] = '{
		7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
		7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
		7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
		7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
		7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
		7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
		7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
		7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h37,
		7'h38, 7'h39, 7'h2D, 7'h34, 7'h35, 7'h36, 7'h2B, 7'h31,
		7'h32, 7'h33, 7'h30, 7'h2E, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
	};

	localparam ascii_t ROM_SHIFT [ROM_SIZE] = '{
		7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
		7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
		7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
		7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
		7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
		7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
		7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
		7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h37,
		7'h38, 7'h39, 7'h2D, 7'h34, 7'h35, 7'h36, 7'h2B, 7'h31,
		7'h32, 7'h33, 7'h30, 7'h2E, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
	};

endpackage

// ===== rtl/scancode_set1_to_ascii_unit.sv =====
// Set-1 scan code to ASCII unit: held-key memory, lock flags, prefix flag and ROM lookup.
// Depends on sc1a_pkg for code constants and the character ROM.
// A result is registered at the edge that accepts its byte.
// Throughput: one byte per cycle unless the output stalls; held-key memory is read at acceptance
// and written back in the next cycle; a pending write is forwarded to a read of the same key.
// Reset: clears the prefix flag, the lock flags, the left shift copy, the output valid flag and
// the per-key valid bits at once, so every key reads as not held with no clearing pass.
module scancode_set1_to_ascii_unit
	import sc1a_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] scan_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       char_valid,
	output logic [6:0] ascii_char,
	output logic       led_write,
	output logic [2:0] led_bits
);

	// Held-key memory: bit 0 plain form held, bit 1 E0 form held.
	held_t key_mem [KEY_COUNT];
	logic [KEY_COUNT-1:0] key_vld_q;

	logic       prefix_q;
	logic [2:0] lock_q;
	held_t      lshift_q;

	// Write-back stage for the held-key read-modify-write.
	logic                 wb_valid_s1;
	logic [KEY_IDX_W-1:0] wb_addr_s1;
	logic                 wb_brk_s1;
	held_t                wb_form_s1;
	held_t                mem_rd_s1;
	logic                 rd_vld_s1;
	logic                 fwd_s1;
	held_t                fwd_data_s1;
	held_t                wb_old;
	held_t                wb_new;

	logic                 in_fire;
	logic                 is_prefix;
	logic [CODE_W-1:0]    code;
	logic [KEY_IDX_W-1:0] addr;
	logic                 in_range;
	logic                 rom_hit;
	logic                 brk;
	logic                 use_key;
	logic                 make;
	held_t                form;
	logic                 is_lock;
	logic [2:0]           lock_next;
	held_t                lshift_next;
	ascii_t               plain;
	ascii_t               shift_ch;
	logic                 shifted;
	logic                 column;
	ascii_t               ch;

	assign in_ready = !out_valid || out_ready;
	assign in_fire  = in_valid && in_ready;

	always_comb begin
		is_prefix = (scan_byte == PREFIX_BYTE);
		code      = scan_byte[CODE_W-1:0];
		addr      = code[KEY_IDX_W-1:0];
		in_range  = (int'(code) < KEY_COUNT);
		rom_hit   = in_range && (int'(code) < ROM_SIZE);
		brk       = scan_byte[7];
		use_key   = !is_prefix && in_range;
		make      = use_key && !brk;
		form      = prefix_q ? 2'b10 : 2'b01;

		is_lock   = make && (code == CODE_NUMLOCK || code == CODE_CAPSLOCK
			|| code == CODE_SCRLOCK);
		lock_next = lock_q;
		if (make && code == CODE_NUMLOCK) begin
			lock_next[LOCK_NUM] = !lock_q[LOCK_NUM];
		end
		if (make && code == CODE_CAPSLOCK) begin
			lock_next[LOCK_CAPS] = !lock_q[LOCK_CAPS];
		end
		if (make && code == CODE_SCRLOCK) begin
			lock_next[LOCK_SCROLL] = !lock_q[LOCK_SCROLL];
		end

		// Left shift entry is mirrored in a register so the shift test needs no second port.
		lshift_next = lshift_q;
		if (use_key && code == CODE_LSHIFT) begin
			lshift_next = brk ? (lshift_q & ~form) : (lshift_q | form);
		end

		plain    = rom_hit ? ROM_PLAIN[addr] : '0;
		shift_ch = rom_hit ? ROM_SHIFT[addr] : '0;
		shifted  = (lock_next[LOCK_CAPS] && plain >= 7'h61 && plain <= 7'h7A)
			^ (|lshift_next);
		column   = prefix_q ? (code != CODE_SLASH) : shifted;
		ch       = column ? shift_ch : plain;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q  <= 1'b0;
			lock_q    <= '0;
			lshift_q  <= '0;
			out_valid <= 1'b0;
		end else begin
			if (in_fire) begin
				prefix_q  <= is_prefix;
				lock_q    <= lock_next;
				lshift_q  <= lshift_next;
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			char_valid <= make && (ch != '0);
			ascii_char <= make ? ch : '0;
			led_write  <= is_lock;
			led_bits   <= lock_next;
		end
	end

	// Write-back control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wb_valid_s1 <= 1'b0;
			key_vld_q   <= '0;
		end else begin
			wb_valid_s1 <= in_fire && use_key;
			if (wb_valid_s1) begin
				key_vld_q[wb_addr_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && use_key) begin
			wb_addr_s1  <= addr;
			wb_brk_s1   <= brk;
			wb_form_s1  <= form;
			rd_vld_s1   <= key_vld_q[addr];
			fwd_s1      <= wb_valid_s1 && (wb_addr_s1 == addr);
			fwd_data_s1 <= wb_new;
		end
	end

	// Memory read port.
	always_ff @(posedge clk) begin
		if (in_fire && use_key) begin
			mem_rd_s1 <= key_mem[addr];
		end
	end

	// Memory write port.
	always_ff @(posedge clk) begin
		if (wb_valid_s1) begin
			key_mem[wb_addr_s1] <= wb_new;
		end
	end

	always_comb begin
		wb_old = fwd_s1 ? fwd_data_s1 : (rd_vld_s1 ? mem_rd_s1 : '0);
		wb_new = wb_brk_s1 ? (wb_old & ~wb_form_s1) : (wb_old | wb_form_s1);
	end

	// The left shift copy must agree with what the memory receives for that key.
	a_lshift_copy: assert property (@(posedge clk) disable iff (!arst_n)
		wb_valid_s1 && wb_addr_s1 == CODE_LSHIFT[KEY_IDX_W-1:0] |-> lshift_q == wb_new)
		else $error("left shift copy differs from held-key memory");

	a_char_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> char_valid == (ascii_char != '0))
		else $error("char_valid does not match ascii_char");

	a_lock_no_char: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && led_write |-> !char_valid)
		else $error("lock key produced a character");

	a_prefix_arm: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && scan_byte == PREFIX_BYTE |=> prefix_q && !led_write && !char_valid)
		else $error("prefix byte not handled");

endmodule

// ===== verif/tb_scancode_set1_to_ascii_unit.sv =====
// Testbench for scancode_set1_to_ascii_unit: directed and random set-1 byte streams,
// random idling on both channels and a scoreboard that predicts every result.
// Depends on sc1a_pkg for scan code constants and on the unit itself.
`timescale 1ns / 100ps

module tb_scancode_set1_to_ascii_unit;
	import sc1a_pkg::*;

	localparam int          ITEM_TARGET = 850;
	localparam int          MAX_WAIT    = 13;
	localparam logic [7:0]  BREAK_FLAG  = 8'h80;
	localparam logic [6:0]  KEY_ESC     = 7'h01;
	localparam logic [6:0]  KEY_1       = 7'h02;
	localparam logic [6:0]  KEY_Q       = 7'h10;
	localparam logic [6:0]  KEY_RETURN  = 7'h1C;
	localparam logic [6:0]  KEY_A       = 7'h1E;
	localparam logic [6:0]  KEY_PAD7    = 7'h47;
	localparam logic [6:0]  KEY_LAST    = 7'h5F;

	// Character map, plain and shifted columns, indexed by make code.
	localparam logic [6:0] MAP_LOWER [96] = '{
		7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
		7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
		7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
		7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
		7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
		7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
		7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
		7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h37,
		7'h38, 7'h39, 7'h2D, 7'h34, 7'h35, 7'h36, 7'h2B, 7'h31,
		7'h32, 7'h33, 7'h30, 7'h2E, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
	};

	localparam logic [6:0] MAP_UPPER [96] = '{
		7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
		7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
		7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
		7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
		7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
		7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
		7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
		7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h37,
		7'h38, 7'h39, 7'h2D, 7'h34, 7'h35, 7'h36, 7'h2B, 7'h31,
		7'h32, 7'h33, 7'h30, 7'h2E, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
	};

	typedef struct packed {
		logic       char_valid;
		logic [6:0] ascii_char;
		logic       led_write;
		logic [2:0] led_bits;
	} key_result_t;

	class keymap_scoreboard;
		logic [1:0]  held_keys [KEY_COUNT];
		logic        e0_armed;
		logic [2:0]  lock_state;
		key_result_t expected_results [$];
		int          mismatch_count;

		function void clear_state();
			foreach (held_keys[i]) held_keys[i] = 2'b00;
			e0_armed = 1'b0;
			lock_state = 3'b000;
			expected_results.delete();
			mismatch_count = 0;
		endfunction

		// Works out the result of one accepted byte and queues it.
		function void predict_byte(logic [7:0] code_byte);
			key_result_t r;
			logic        ext;
			logic [6:0]  code;
			logic [1:0]  form;
			logic [6:0]  lower;
			logic        use_upper;
			r = '0;
			if (code_byte == PREFIX_BYTE) begin
				e0_armed = 1'b1;
			end else begin
				ext = e0_armed;
				e0_armed = 1'b0;
				code = code_byte[6:0];
				form = ext ? 2'b10 : 2'b01;
				if (int'(code) < KEY_COUNT) begin
					if (code_byte[7]) begin
						held_keys[code] = held_keys[code] & ~form;
					end else begin
						held_keys[code] = held_keys[code] | form;
						if (code == CODE_NUMLOCK) begin
							lock_state[LOCK_NUM] = ~lock_state[LOCK_NUM];
							r.led_write = 1'b1;
						end else if (code == CODE_CAPSLOCK) begin
							lock_state[LOCK_CAPS] = ~lock_state[LOCK_CAPS];
							r.led_write = 1'b1;
						end else if (code == CODE_SCRLOCK) begin
							lock_state[LOCK_SCROLL] = ~lock_state[LOCK_SCROLL];
							r.led_write = 1'b1;
						end
						lower = (code < 96) ? MAP_LOWER[code] : 7'h00;
						use_upper = (lock_state[LOCK_CAPS] && lower >= 7'h61 && lower <= 7'h7A)
							^ (held_keys[CODE_LSHIFT] != 2'b00);
						// Extended codes ignore shift and caps and take the shifted column; only slash stays plain.
						if (ext)
							use_upper = (code != CODE_SLASH);
						if (code < 96)
							r.ascii_char = use_upper ? MAP_UPPER[code] : lower;
						r.char_valid = (r.ascii_char != 7'h00);
					end
				end
			end
			r.led_bits = lock_state;
			expected_results.push_back(r);
		endfunction

		function void check_result(key_result_t got);
			key_result_t want;
			if (expected_results.size() == 0) begin
				$error("result with nothing expected: %h", got);
				mismatch_count++;
				return;
			end
			want = expected_results.pop_front();
			if (got.char_valid !== want.char_valid) begin
				$error("char_valid: expected %b, actual %b", want.char_valid, got.char_valid);
				mismatch_count++;
			end
			if (got.ascii_char !== want.ascii_char) begin
				$error("ascii_char: expected %h, actual %h", want.ascii_char, got.ascii_char);
				mismatch_count++;
			end
			if (got.led_write !== want.led_write) begin
				$error("led_write: expected %b, actual %b", want.led_write, got.led_write);
				mismatch_count++;
			end
			if (got.led_bits !== want.led_bits) begin
				$error("led_bits: expected %b, actual %b", want.led_bits, got.led_bits);
				mismatch_count++;
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] scan_byte;
	logic       out_valid;
	logic       out_ready;
	logic       char_valid;
	logic [6:0] ascii_char;
	logic       led_write;
	logic [2:0] led_bits;

	keymap_scoreboard sb;
	int   bytes_sent;
	logic gapless;

	scancode_set1_to_ascii_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.scan_byte  (scan_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.char_valid (char_valid),
		.ascii_char (ascii_char),
		.led_write  (led_write),
		.led_bits   (led_bits)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			sb.predict_byte(scan_byte);
		if (arst_n && out_valid && out_ready)
			sb.check_result('{char_valid, ascii_char, led_write, led_bits});
	end

	// Valid stays high across back-to-back transfers; it only drops for a gap.
	task automatic send_byte(input logic [7:0] code_byte);
		int gap;
		gap = gapless ? 0 : $urandom_range(0, MAX_WAIT);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		scan_byte <= code_byte;
		do @(posedge clk); while (!in_ready);
		bytes_sent++;
	endtask

	task automatic press_key(input logic [6:0] code, input logic ext, input logic is_break);
		if (ext)
			send_byte(PREFIX_BYTE);
		send_byte({is_break, code});
	endtask

	task automatic random_keystroke();
		int         pick;
		logic [6:0] code;
		logic       ext;
		pick = $urandom_range(0, 99);
		ext = ($urandom_range(0, 4) == 0);
		if (pick < 12) begin
			send_byte(8'($urandom_range(0, 255)));
		end else if (pick < 22) begin
			press_key(CODE_LSHIFT, ext, 1'($urandom_range(0, 1)));
		end else if (pick < 28) begin
			case ($urandom_range(0, 2))
				0: code = CODE_NUMLOCK;
				1: code = CODE_CAPSLOCK;
				default: code = CODE_SCRLOCK;
			endcase
			press_key(code, ext, 1'b0);
			if ($urandom_range(0, 1))
				press_key(code, ext, 1'b1);
		end else begin
			code = 7'($urandom_range(0, KEY_COUNT - 1));
			press_key(code, ext, 1'b0);
			if ($urandom_range(0, 9) < 7)
				press_key(code, ext, 1'b1);
		end
	endtask

	// Result side: a fresh stall is drawn before every transfer.
	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = gapless ? 0 : $urandom_range(0, MAX_WAIT);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		#5_000_000;
		$display("scancode_set1_to_ascii_unit: mismatch");
		$finish;
	end

	initial begin
		int guard;
		sb = new;
		sb.clear_state();
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		scan_byte = 8'h00;
		bytes_sent = 0;
		gapless = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Prefix handling, including a repeated prefix and the extended slash.
		send_byte(PREFIX_BYTE);
		send_byte(PREFIX_BYTE);
		send_byte({1'b0, CODE_SLASH});
		press_key(CODE_SLASH, 1'b0, 1'b0);
		send_byte(8'h00);
		send_byte(8'h7F);
		send_byte(8'hFF);
		press_key(KEY_LAST, 1'b0, 1'b0);
		// CapsLock flips letters only; a held left shift flips them back.
		press_key(KEY_A, 1'b0, 1'b0);
		press_key(CODE_CAPSLOCK, 1'b0, 1'b0);
		press_key(KEY_A, 1'b0, 1'b0);
		press_key(CODE_LSHIFT, 1'b0, 1'b0);
		press_key(KEY_A, 1'b0, 1'b0);
		press_key(KEY_1, 1'b0, 1'b0);
		press_key(CODE_LSHIFT, 1'b0, 1'b1);
		press_key(CODE_CAPSLOCK, 1'b1, 1'b0);
		press_key(CODE_NUMLOCK, 1'b0, 1'b0);
		press_key(CODE_SCRLOCK, 1'b1, 1'b0);
		// Shift held in its extended form only.
		press_key(CODE_LSHIFT, 1'b1, 1'b0);
		press_key(KEY_Q, 1'b0, 1'b0);
		press_key(CODE_LSHIFT, 1'b1, 1'b1);
		press_key(KEY_RETURN, 1'b1, 1'b0);
		press_key(KEY_PAD7, 1'b1, 1'b0);
		press_key(KEY_ESC, 1'b1, 1'b1);
		send_byte(BREAK_FLAG);

		while (bytes_sent < ITEM_TARGET) begin
			if ($urandom_range(0, 59) == 0)
				gapless = ~gapless;
			random_keystroke();
		end
		in_valid <= 1'b0;
		gapless = 1'b0;

		guard = 0;
		while (sb.expected_results.size() != 0 && guard < 5000) begin
			@(posedge clk);
			guard++;
		end
		repeat (10) @(posedge clk);
		if (sb.expected_results.size() != 0) begin
			$error("%0d expected results never arrived", sb.expected_results.size());
			sb.mismatch_count++;
		end
		if (sb.mismatch_count == 0)
			$display("scancode_set1_to_ascii_unit: match");
		else
			$display("scancode_set1_to_ascii_unit: mismatch");
		$finish;
	end

endmodule
